/* hdl/ksrq_pkg.sv */
package ksrq_pkg;

  // Number of key-matrix bytes that take part in a scan; only two exist.
  localparam int SCAN_BYTES = 2;
  localparam int SCAN_INPUTS = 2;
  localparam int SCAN_USED = (SCAN_BYTES > SCAN_INPUTS) ? SCAN_INPUTS :
                             ((SCAN_BYTES < 1) ? 1 : SCAN_BYTES);

  localparam int KEY_W = 4;
  localparam int CNT_W = 8;

  localparam logic [CNT_W-1:0] THRESH_RESET = 8'd3;
  localparam logic [CNT_W-1:0] HOLD_MAX     = 8'hFF;

  typedef logic [7:0]       scan_byte_t;
  typedef logic [KEY_W-1:0] key_code_t;
  typedef logic [CNT_W-1:0] hold_cnt_t;

  typedef struct packed {
    logic      found;
    key_code_t code;
  } key_hit_t;

endpackage

/* hdl/ksrq_key_encoder.sv */
module ksrq_key_encoder (
  input  ksrq_pkg::scan_byte_t scan_low,
  input  ksrq_pkg::scan_byte_t scan_high,
  output ksrq_pkg::key_hit_t   hit
);
  import ksrq_pkg::*;

  scan_byte_t bytes [SCAN_INPUTS];

  function automatic logic [2:0] lowest_bit(input scan_byte_t b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        idx = i[2:0];
      end
    end
    return idx;
  endfunction

  assign bytes[0] = scan_low;
  assign bytes[1] = scan_high;

  // The later non-zero byte wins; the lowest set bit inside it picks the key.
  always_comb begin
    hit.found = 1'b0;
    hit.code  = '0;
    for (int pos = 0; pos < SCAN_USED; pos++) begin
      if (bytes[pos] != '0) begin
        hit.found = 1'b1;
        hit.code  = {pos[0], lowest_bit(bytes[pos])};
      end
    end
  end

endmodule

/* hdl/key_scan_repeat_qualifier_unit.sv */
// Key scan qualifier with auto-repeat. Each input word is one scan of the
// key matrix (two bytes); the block reports a key code when a new key
// appears and again each time a held key's count exceeds cfg_wr_data as
// written to the repeat threshold (reset value 3). Empty scans forget the
// held key and produce nothing. A word is taken every cycle unless a result
// is waiting on a stalled output; its result, if any, reaches the output
// through an input register and a result register, with the encode and
// count update between them. The threshold should only be written while no
// scan is in flight.
module key_scan_repeat_qualifier_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  ksrq_pkg::hold_cnt_t  cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ksrq_pkg::scan_byte_t in_scan_low,
  input  ksrq_pkg::scan_byte_t in_scan_high,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ksrq_pkg::key_code_t  out_key_code
);
  import ksrq_pkg::*;

  hold_cnt_t  thresh_r;
  logic       in_valid_r;
  scan_byte_t scan_low_r;
  scan_byte_t scan_high_r;
  key_code_t  last_key_r, last_key_nxt;
  logic       last_valid_r, last_valid_nxt;
  hold_cnt_t  hold_cnt_r, hold_cnt_nxt;
  logic       out_valid_r;
  key_code_t  out_key_r;

  key_hit_t   hit;
  logic       emit;
  logic       advance;
  hold_cnt_t  hold_base;

  ksrq_key_encoder u_enc (
    .scan_low  (scan_low_r),
    .scan_high (scan_high_r),
    .hit       (hit)
  );

  always_comb begin
    emit           = 1'b0;
    last_key_nxt   = last_key_r;
    last_valid_nxt = last_valid_r;
    hold_cnt_nxt   = hold_cnt_r;
    hold_base      = hold_cnt_r;
    if (!hit.found) begin
      last_key_nxt   = '0;
      last_valid_nxt = 1'b0;
      hold_cnt_nxt   = '0;
    end else if (!last_valid_r || last_key_r != hit.code) begin
      emit           = 1'b1;
      last_key_nxt   = hit.code;
      last_valid_nxt = 1'b1;
      hold_cnt_nxt   = '0;
    end else begin
      // A repeat restarts the count, which is then bumped to one.
      if (hold_cnt_r > thresh_r) begin
        emit      = 1'b1;
        hold_base = '0;
      end
      hold_cnt_nxt = (hold_base != HOLD_MAX) ? hold_base + 1'b1 : hold_base;
    end
  end

  // A scan without a result may always move on; one with a result needs room.
  assign advance  = in_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RESET;
      in_valid_r   <= 1'b0;
      last_key_r   <= '0;
      last_valid_r <= 1'b0;
      hold_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        last_key_r   <= last_key_nxt;
        last_valid_r <= last_valid_nxt;
        hold_cnt_r   <= hold_cnt_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      scan_low_r  <= in_scan_low;
      scan_high_r <= in_scan_high;
    end
    if (advance && emit) begin
      out_key_r <= hit.code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_key_r;

  a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !hit.found |=> !last_valid_r && hold_cnt_r == '0)
    else $error("empty scan did not clear the held key");

  a_new_key_emits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && hit.found && (!last_valid_r || last_key_r != hit.code)
    |=> out_valid_r && out_key_r == $past(hit.code))
    else $error("new key was not reported");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(advance && emit))
    else $error("pending result overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ksrq_pkg::*;

  // Follows the block's key qualifier and keeps the key events that are due.
  class key_event_board;
    key_code_t pending_keys[$];
    int        errors;
    hold_cnt_t threshold;
    key_code_t held_key;
    bit        key_held;
    hold_cnt_t hold_count;

    function new();
      threshold  = THRESH_RESET;
      held_key   = '0;
      key_held   = 1'b0;
      hold_count = '0;
      errors     = 0;
    endfunction

    function void set_threshold(hold_cnt_t value);
      threshold = value;
    endfunction

    function void note_scan(scan_byte_t scan_lo, scan_byte_t scan_hi);
      scan_byte_t bytes [2];
      bit         found;
      key_code_t  key;
      bytes[0] = scan_lo;
      bytes[1] = scan_hi;
      found = 1'b0;
      key = '0;
      // The last non-zero byte wins, and within it the lowest set bit.
      for (int p = 0; p < SCAN_USED; p++) begin
        if (bytes[p] != '0) begin
          found = 1'b1;
          for (int b = 7; b >= 0; b--) begin
            if (bytes[p][b]) key = key_code_t'(b + 8 * p);
          end
        end
      end
      if (!found) begin
        key_held   = 1'b0;
        held_key   = '0;
        hold_count = '0;
        return;
      end
      if (!key_held || held_key != key) begin
        key_held   = 1'b1;
        held_key   = key;
        hold_count = '0;
        pending_keys.push_back(key);
        return;
      end
      if (hold_count > threshold) begin
        hold_count = '0;
        pending_keys.push_back(key);
      end
      if (hold_count != HOLD_MAX) hold_count++;
    endfunction

    function void check_key(key_code_t actual);
      key_code_t wanted;
      if (pending_keys.size() == 0) begin
        $error("key_code: no word expected, actual %0d", actual);
        errors++;
        return;
      end
      wanted = pending_keys.pop_front();
      if (actual !== wanted) begin
        $error("key_code: expected %0d, actual %0d", wanted, actual);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  hold_cnt_t  cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  scan_byte_t in_scan_low = '0;
  scan_byte_t in_scan_high = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  key_code_t  out_key_code;

  key_event_board board = new();
  int burst_left = 0;
  int stall_cycle = 0;
  int stall_mode = 0;

  key_scan_repeat_qualifier_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scan_low  (in_scan_low),
    .in_scan_high (in_scan_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code)
  );

  always #5 clk = ~clk;

  // Result side: check accepted words and stall in a mode that is drawn anew
  // at random (free running, random, or long periodic stalls).
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_key(out_key_code);
    if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ((stall_cycle % 8) < 5);
      end
    endcase
    stall_cycle++;
  end

  task automatic send_scan(scan_byte_t scan_lo, scan_byte_t scan_hi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_scan_low  <= scan_lo;
    in_scan_high <= scan_hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_scan(scan_lo, scan_hi);
    burst_left--;
  endtask

  // Builds a scan that selects the given key, with random bits that do not
  // change the choice.
  task automatic send_key(int key);
    scan_byte_t scan_lo;
    scan_byte_t scan_hi;
    scan_byte_t noise;
    noise = scan_byte_t'($urandom_range(0, 255));
    if (key >= 8) begin
      scan_hi = (noise << (key - 7)) | (scan_byte_t'(1) << (key - 8));
      scan_lo = scan_byte_t'($urandom_range(0, 255));
    end else begin
      scan_hi = '0;
      scan_lo = (noise << (key + 1)) | (scan_byte_t'(1) << key);
    end
    send_scan(scan_lo, scan_hi);
  endtask

  task automatic hold_key(int key, int scans);
    repeat (scans) send_key(key);
  endtask

  // Drains the block: no word is expected and the pipeline is empty.
  task automatic settle_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_keys.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(hold_cnt_t value);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_threshold(value);
  endtask

  // Mostly held keys of random length, mixed with empty scans and noise.
  task automatic run_phase(hold_cnt_t value, int scans, int max_hold);
    int sent;
    int pick;
    int len;
    write_threshold(value);
    sent = 0;
    while (sent < scans) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(1, max_hold);
        hold_key($urandom_range(0, 15), len);
        sent += len;
      end else if (pick == 7) begin
        send_scan('0, '0);
        sent++;
      end else begin
        send_scan(scan_byte_t'($urandom_range(0, 255)), scan_byte_t'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    hold_cnt_t pick_thr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans at the reset threshold.
    send_scan(8'h00, 8'h00);
    send_scan(8'h01, 8'h00);
    send_scan(8'h80, 8'h00);
    send_scan(8'h00, 8'h01);
    send_scan(8'h00, 8'h80);
    send_scan(8'hFF, 8'hFF);
    send_scan(8'h06, 8'h00);
    hold_key(1, 6);
    send_scan(8'h00, 8'h00);
    send_scan(8'h02, 8'h00);
    send_scan(8'h55, 8'h00);
    send_scan(8'h00, 8'hAA);
    send_scan(8'hFF, 8'hAA);
    send_scan(8'h00, 8'h00);

    run_phase(8'd0, 180, 6);
    run_phase(8'd1, 180, 8);

    // Threshold 254: a long hold runs the count up to its top value, 255.
    write_threshold(8'd254);
    hold_key(12, 300);
    run_phase(8'd254, 80, 40);

    pick_thr = hold_cnt_t'($urandom_range(2, 20));
    run_phase(pick_thr, 220, 3 * pick_thr + 4);
    run_phase(hold_cnt_t'($urandom_range(0, 254)), 150, 40);
    run_phase(8'd3, 180, 14);

    settle_idle();
    if (board.errors == 0 && board.pending_keys.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
hdl/ksrq_pkg.sv
hdl/ksrq_key_encoder.sv
hdl/key_scan_repeat_qualifier_unit.sv
tb/testbench.sv
